>>> design/timespec_arithmetic_unit_assert.svh
// Assertion macros for the timestamp arithmetic unit.
`ifndef TIMESPEC_ARITHMETIC_UNIT_ASSERT_SVH
`define TIMESPEC_ARITHMETIC_UNIT_ASSERT_SVH
`ifndef ASSERT_OFF
`define TSAU_ASSERT_IMP(lbl, ck, rn, ante, cons) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
        else $error("timestamp unit: same-cycle check failed");
`define TSAU_ASSERT_NXT(lbl, ck, rn, ante, cons) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
        else $error("timestamp unit: next-cycle check failed");
`else
`define TSAU_ASSERT_IMP(lbl, ck, rn, ante, cons)
`define TSAU_ASSERT_NXT(lbl, ck, rn, ante, cons)
`endif
`endif

>>> design/tsau_pkg.sv
// Shared constants and codes for the timestamp arithmetic unit.
`default_nettype none
package tsau_pkg;
    localparam int SEC_W      = 64;
    localparam int NSEC_W     = 30;
    localparam int RES_NSEC_W = 31;
    localparam int FACTOR_W   = 32;
    localparam int DIV_W      = 32;
    localparam int DVD1_W     = 64;
    localparam int DVD2_W     = 62;
    localparam int HI_W       = 97;
    localparam int TQ_W       = 34;

    localparam logic [DIV_W-1:0] NS_PER_SEC     = 32'd1000000000;
    localparam logic [DIV_W-1:0] TWO_NS_PER_SEC = 32'd2000000000;

    typedef enum logic [1:0] {
        CMD_DIFF = 2'd0,
        CMD_SUM  = 2'd1,
        CMD_MUL  = 2'd2,
        CMD_DIV  = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_DIV_ZERO = 2'd1,
        ST_OVERFLOW = 2'd2
    } status_t;
endpackage
`default_nettype wire

>>> design/tsau_div_cell.sv
// One restoring divide step: produces one quotient bit and passes the word on.
`default_nettype none
module tsau_div_cell #(
    parameter int DW = tsau_pkg::DVD1_W,
    parameter int SW = 1
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       en,
    input  logic                       in_valid,
    input  logic [tsau_pkg::DIV_W-1:0] in_rem,
    input  logic [tsau_pkg::DIV_W-1:0] in_div,
    input  logic [DW-1:0]              in_dvd,
    input  logic [SW-1:0]              in_side,
    output logic                       out_valid,
    output logic [tsau_pkg::DIV_W-1:0] out_rem,
    output logic [tsau_pkg::DIV_W-1:0] out_div,
    output logic [DW-1:0]              out_dvd,
    output logic [SW-1:0]              out_side
);
    import tsau_pkg::*;

    logic [DIV_W:0]   shifted;
    logic [DIV_W:0]   diff;
    logic             ge;
    logic [DIV_W-1:0] rem_next;
    logic [DW-1:0]    dvd_next;

    logic             valid_reg;
    logic [DIV_W-1:0] rem_reg;
    logic [DIV_W-1:0] div_reg;
    logic [DW-1:0]    dvd_reg;
    logic [SW-1:0]    side_reg;

    always_comb
    begin
        shifted  = {in_rem, in_dvd[DW-1]};
        diff     = shifted - {1'b0, in_div};
        ge       = (shifted >= {1'b0, in_div});
        rem_next = ge ? diff[DIV_W-1:0] : shifted[DIV_W-1:0];
        // shift the dividend out the top, the quotient bit in at the bottom
        dvd_next = {in_dvd[DW-2:0], ge};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg  <= rem_next;
            div_reg  <= in_div;
            dvd_reg  <= dvd_next;
            side_reg <= in_side;
        end
    end

    assign out_valid = valid_reg;
    assign out_rem   = rem_reg;
    assign out_div   = div_reg;
    assign out_dvd   = dvd_reg;
    assign out_side  = side_reg;
endmodule
`default_nettype wire

>>> design/tsau_div_chain.sv
// Row of divide cells: one quotient bit per cell, one word per cycle while en is high.
`default_nettype none
module tsau_div_chain #(
    parameter int DW = tsau_pkg::DVD1_W,
    parameter int SW = 1
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       en,
    input  logic                       in_valid,
    input  logic [DW-1:0]              in_dvd,
    input  logic [tsau_pkg::DIV_W-1:0] in_div,
    input  logic [SW-1:0]              in_side,
    output logic                       out_valid,
    output logic [DW-1:0]              out_quo,
    output logic [tsau_pkg::DIV_W-1:0] out_rem,
    output logic [tsau_pkg::DIV_W-1:0] out_div,
    output logic [SW-1:0]              out_side
);
    import tsau_pkg::*;

    logic [DW:0]      v;
    logic [DIV_W-1:0] rem  [0:DW];
    logic [DIV_W-1:0] dv   [0:DW];
    logic [DW-1:0]    dvd  [0:DW];
    logic [SW-1:0]    side [0:DW];

    assign v[0]    = in_valid;
    assign rem[0]  = '0;
    assign dv[0]   = in_div;
    assign dvd[0]  = in_dvd;
    assign side[0] = in_side;

    for (genvar i = 0; i < DW; i++)
    begin : g_cell
        tsau_div_cell #(
            .DW (DW),
            .SW (SW)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (en),
            .in_valid  (v[i]),
            .in_rem    (rem[i]),
            .in_div    (dv[i]),
            .in_dvd    (dvd[i]),
            .in_side   (side[i]),
            .out_valid (v[i+1]),
            .out_rem   (rem[i+1]),
            .out_div   (dv[i+1]),
            .out_dvd   (dvd[i+1]),
            .out_side  (side[i+1])
        );
    end

    assign out_valid = v[DW];
    assign out_quo   = dvd[DW];
    assign out_rem   = rem[DW];
    assign out_div   = dv[DW];
    assign out_side  = side[DW];
endmodule
`default_nettype wire

>>> design/timespec_arithmetic_unit.sv
// Top level of the seconds-plus-nanoseconds arithmetic unit.
// The unit takes one word per clock unless the pipe holds, and returns one
// result word per input word, in order. Its pipe is built from two
// rows of restoring divide cells, one quotient bit per cell: a 64-cell row
// for seconds by factor and a 62-cell row that either splits the scaled
// remainder by the factor or splits a product by one billion. Around them
// sit an input stage with the multipliers, two staging registers between
// the rows, one after the second row, and the output register. The whole
// pipe advances together; it holds only while a result waits at the output.
`default_nettype none
`include "timespec_arithmetic_unit_assert.svh"
module timespec_arithmetic_unit (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  logic [1:0]                           cmd,
    input  logic signed [tsau_pkg::SEC_W-1:0]    a_sec,
    input  logic [tsau_pkg::NSEC_W-1:0]          a_nsec,
    input  logic signed [tsau_pkg::SEC_W-1:0]    b_sec,
    input  logic [tsau_pkg::NSEC_W-1:0]          b_nsec,
    input  logic signed [tsau_pkg::FACTOR_W-1:0] factor,
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output logic signed [tsau_pkg::SEC_W-1:0]    res_sec,
    output logic signed [tsau_pkg::RES_NSEC_W-1:0] res_nsec,
    output logic [1:0]                           status
);
    import tsau_pkg::*;

    typedef struct packed {
        logic [SEC_W-1:0]      sec;
        logic [RES_NSEC_W-1:0] nsec;
        logic                  ovf;
    } as_t;

    typedef struct packed {
        cmd_t              cmd;
        logic              a_neg;
        logic              f_neg;
        logic              div0;
        logic [NSEC_W-1:0] a_nsec;
        as_t               as_res;
        logic [63:0]       p_lo;
        logic [63:0]       p_hi;
        logic [DVD2_W-1:0] tm;
    } side1_t;

    typedef struct packed {
        cmd_t              cmd;
        logic              a_neg;
        logic              f_neg;
        logic              div0;
        logic [NSEC_W-1:0] a_nsec;
        as_t               as_res;
        logic [DIV_W-1:0]  fm;
        logic [95:0]       prod_mag;
        logic [DVD2_W-1:0] tm;
        logic [63:0]       qm;
        logic [DVD2_W-1:0] rprod;
    } q_t;

    typedef struct packed {
        cmd_t            cmd;
        logic            div0;
        logic            t_neg;
        logic [HI_W-1:0] hi_s;
        as_t             as_res;
    } side2_t;

    typedef struct packed {
        cmd_t                  cmd;
        logic                  div0;
        logic [HI_W-1:0]       hi_s;
        logic [TQ_W-1:0]       tq;
        logic [RES_NSEC_W-1:0] nsec;
        as_t                   as_res;
    } u_t;

    localparam int S1_W = $bits(side1_t);
    localparam int S2_W = $bits(side2_t);

    logic adv;

    // ---------------- input stage: add/sub, magnitudes, multipliers
    logic [31:0]      d0, d1, d2, s0, s1, s2;
    logic [1:0]       borrows, carries;
    logic [SEC_W+1:0] a_ext, b_ext, as_wide;
    logic [SEC_W-1:0] am;
    logic [DIV_W-1:0] fm;
    side1_t           p_side_next;

    logic             p_valid_reg;
    side1_t           p_side_reg;
    logic [SEC_W-1:0] p_am_reg;
    logic [DIV_W-1:0] p_fm_reg;

    always_comb
    begin
        d0 = {2'b00, a_nsec} - {2'b00, b_nsec};
        d1 = d0[31] ? d0 + NS_PER_SEC : d0;
        d2 = d1[31] ? d1 + NS_PER_SEC : d1;
        borrows = {1'b0, d0[31]} + {1'b0, d1[31]};
        s0 = {2'b00, a_nsec} + {2'b00, b_nsec};
        s1 = (s0 >= NS_PER_SEC) ? s0 - NS_PER_SEC : s0;
        s2 = (s1 >= NS_PER_SEC) ? s1 - NS_PER_SEC : s1;
        carries = {1'b0, s0 >= NS_PER_SEC} + {1'b0, s1 >= NS_PER_SEC};
        a_ext = {{2{a_sec[SEC_W-1]}}, a_sec};
        b_ext = {{2{b_sec[SEC_W-1]}}, b_sec};
        if (cmd == CMD_DIFF)
        begin
            as_wide = a_ext - b_ext - {{SEC_W{1'b0}}, borrows};
        end
        else
        begin
            as_wide = a_ext + b_ext + {{SEC_W{1'b0}}, carries};
        end

        am = a_sec[SEC_W-1] ? (~a_sec + 64'd1) : a_sec;
        fm = factor[FACTOR_W-1] ? (~factor + 32'd1) : factor;

        p_side_next.cmd         = cmd_t'(cmd);
        p_side_next.a_neg       = a_sec[SEC_W-1];
        p_side_next.f_neg       = factor[FACTOR_W-1];
        p_side_next.div0        = (cmd == CMD_DIV) && (factor == '0);
        p_side_next.a_nsec      = a_nsec;
        p_side_next.as_res.sec  = as_wide[SEC_W-1:0];
        p_side_next.as_res.nsec = (cmd == CMD_DIFF) ? d2[RES_NSEC_W-1:0]
                                                    : s2[RES_NSEC_W-1:0];
        p_side_next.as_res.ovf  = !((as_wide[SEC_W+1:SEC_W-1] == 3'b000) ||
                                    (as_wide[SEC_W+1:SEC_W-1] == 3'b111));
        p_side_next.p_lo        = {32'b0, am[31:0]} * {32'b0, fm};
        p_side_next.p_hi        = {32'b0, am[63:32]} * {32'b0, fm};
        p_side_next.tm          = {30'b0, fm} * {32'b0, a_nsec};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            p_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            p_side_reg <= p_side_next;
            p_am_reg   <= am;
            p_fm_reg   <= fm;
        end
    end

    // ---------------- seconds magnitude / factor magnitude
    logic             c1_valid;
    logic [DVD1_W-1:0] c1_quo;
    logic [DIV_W-1:0] c1_rem, c1_div;
    logic [S1_W-1:0]  c1_side_bits;
    side1_t           c1_side;

    tsau_div_chain #(
        .DW (DVD1_W),
        .SW (S1_W)
    ) u_chain_sec (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (adv),
        .in_valid  (p_valid_reg),
        .in_dvd    (p_am_reg),
        .in_div    (p_fm_reg),
        .in_side   (p_side_reg),
        .out_valid (c1_valid),
        .out_quo   (c1_quo),
        .out_rem   (c1_rem),
        .out_div   (c1_div),
        .out_side  (c1_side_bits)
    );

    assign c1_side = side1_t'(c1_side_bits);

    // ---------------- stage Q: combine partial products, scale remainder
    q_t   q_next;
    logic q_valid_reg;
    q_t   q_reg;

    always_comb
    begin
        q_next.cmd      = c1_side.cmd;
        q_next.a_neg    = c1_side.a_neg;
        q_next.f_neg    = c1_side.f_neg;
        q_next.div0     = c1_side.div0;
        q_next.a_nsec   = c1_side.a_nsec;
        q_next.as_res   = c1_side.as_res;
        q_next.fm       = c1_div;
        q_next.prod_mag = {32'b0, c1_side.p_lo} + {c1_side.p_hi, 32'b0};
        q_next.tm       = c1_side.tm;
        q_next.qm       = c1_quo;
        q_next.rprod    = {30'b0, c1_rem} * {32'b0, NS_PER_SEC[NSEC_W-1:0]};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            q_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            q_valid_reg <= c1_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            q_reg <= q_next;
        end
    end

    // ---------------- stage R: signs applied, second divide operands
    logic [DVD2_W:0]   numer;
    logic [DVD2_W:0]   numer_abs;
    logic [HI_W-1:0]   hi_mag;
    side2_t            r_side_next;
    logic [DVD2_W-1:0] r_dvd_next;
    logic [DIV_W-1:0]  r_div_next;

    logic              r_valid_reg;
    side2_t            r_side_reg;
    logic [DVD2_W-1:0] r_dvd_reg;
    logic [DIV_W-1:0]  r_div_reg;

    always_comb
    begin
        // remainder carries the sign of the seconds operand
        if (q_reg.a_neg)
        begin
            numer = {33'b0, q_reg.a_nsec} - {1'b0, q_reg.rprod};
        end
        else
        begin
            numer = {1'b0, q_reg.rprod} + {33'b0, q_reg.a_nsec};
        end
        numer_abs = numer[DVD2_W] ? (~numer + 63'd1) : numer;

        if (q_reg.cmd == CMD_MUL)
        begin
            hi_mag = {1'b0, q_reg.prod_mag};
        end
        else
        begin
            hi_mag = {33'b0, q_reg.qm};
        end

        r_side_next.cmd    = q_reg.cmd;
        r_side_next.div0   = q_reg.div0;
        r_side_next.as_res = q_reg.as_res;
        r_side_next.hi_s   = (q_reg.a_neg ^ q_reg.f_neg) ? (~hi_mag + 97'd1) : hi_mag;
        if (q_reg.cmd == CMD_MUL)
        begin
            r_dvd_next        = q_reg.tm;
            r_div_next        = NS_PER_SEC;
            r_side_next.t_neg = q_reg.f_neg;
        end
        else
        begin
            r_dvd_next        = numer_abs[DVD2_W-1:0];
            r_div_next        = q_reg.fm;
            r_side_next.t_neg = numer[DVD2_W] ^ q_reg.f_neg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            r_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            r_valid_reg <= q_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            r_side_reg <= r_side_next;
            r_dvd_reg  <= r_dvd_next;
            r_div_reg  <= r_div_next;
        end
    end

    // ---------------- product / billion, or scaled remainder / factor
    logic              c2_valid;
    logic [DVD2_W-1:0] c2_quo;
    logic [DIV_W-1:0]  c2_rem, c2_div;
    logic [S2_W-1:0]   c2_side_bits;
    side2_t            c2_side;

    tsau_div_chain #(
        .DW (DVD2_W),
        .SW (S2_W)
    ) u_chain_ns (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (adv),
        .in_valid  (r_valid_reg),
        .in_dvd    (r_dvd_reg),
        .in_div    (r_div_reg),
        .in_side   (r_side_reg),
        .out_valid (c2_valid),
        .out_quo   (c2_quo),
        .out_rem   (c2_rem),
        .out_div   (c2_div),
        .out_side  (c2_side_bits)
    );

    assign c2_side = side2_t'(c2_side_bits);

    // ---------------- stage U: split t into seconds and nanoseconds
    logic [31:0]     tmag, tq_mag, t_sub, t_left;
    logic [NSEC_W-1:0] ns_mag;
    logic            ge1, ge2;
    u_t              u_next;
    logic            u_valid_reg;
    u_t              u_reg;

    always_comb
    begin
        tmag = c2_quo[31:0];
        ge2  = (tmag >= TWO_NS_PER_SEC);
        ge1  = (tmag >= NS_PER_SEC);
        t_sub  = ge2 ? TWO_NS_PER_SEC : (ge1 ? NS_PER_SEC : 32'd0);
        t_left = tmag - t_sub;
        if (c2_side.cmd == CMD_MUL)
        begin
            // divisor was one billion: quotient and remainder are ready
            tq_mag = tmag;
            ns_mag = c2_rem[NSEC_W-1:0];
        end
        else
        begin
            tq_mag = ge2 ? 32'd2 : (ge1 ? 32'd1 : 32'd0);
            ns_mag = t_left[NSEC_W-1:0];
        end
        u_next.cmd    = c2_side.cmd;
        u_next.div0   = c2_side.div0;
        u_next.hi_s   = c2_side.hi_s;
        u_next.as_res = c2_side.as_res;
        u_next.tq     = c2_side.t_neg ? (~{2'b00, tq_mag} + 34'd1) : {2'b00, tq_mag};
        u_next.nsec   = c2_side.t_neg ? (~{1'b0, ns_mag} + 31'd1) : {1'b0, ns_mag};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            u_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            u_valid_reg <= c2_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            u_reg <= u_next;
        end
    end

    // ---------------- output register: final seconds add, status
    logic [HI_W:0]         sec_wide;
    logic                  sec_fits;
    logic [SEC_W-1:0]      res_sec_next;
    logic [RES_NSEC_W-1:0] res_nsec_next;
    status_t               status_next;

    logic                  out_valid_reg;
    logic [SEC_W-1:0]      res_sec_reg;
    logic [RES_NSEC_W-1:0] res_nsec_reg;
    status_t               status_reg;

    always_comb
    begin
        sec_wide = {u_reg.hi_s[HI_W-1], u_reg.hi_s}
                 + {{(HI_W+1-TQ_W){u_reg.tq[TQ_W-1]}}, u_reg.tq};
        sec_fits = (&sec_wide[HI_W:SEC_W-1]) || !(|sec_wide[HI_W:SEC_W-1]);
        if ((u_reg.cmd == CMD_DIFF) || (u_reg.cmd == CMD_SUM))
        begin
            res_sec_next  = u_reg.as_res.sec;
            res_nsec_next = u_reg.as_res.nsec;
            status_next   = u_reg.as_res.ovf ? ST_OVERFLOW : ST_OK;
        end
        else if (u_reg.div0)
        begin
            res_sec_next  = '0;
            res_nsec_next = '0;
            status_next   = ST_DIV_ZERO;
        end
        else
        begin
            res_sec_next  = sec_wide[SEC_W-1:0];
            res_nsec_next = u_reg.nsec;
            status_next   = sec_fits ? ST_OK : ST_OVERFLOW;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            out_valid_reg <= u_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            res_sec_reg  <= res_sec_next;
            res_nsec_reg <= res_nsec_next;
            status_reg   <= status_next;
        end
    end

    // advance the whole pipe unless a result waits at the output
    assign adv       = !out_valid_reg || out_ready;
    assign in_ready  = adv;
    assign out_valid = out_valid_reg;
    assign res_sec   = res_sec_reg;
    assign res_nsec  = res_nsec_reg;
    assign status    = status_reg;

    `TSAU_ASSERT_IMP(a_divzero_clear, clk, rst_n, out_valid && status == ST_DIV_ZERO, res_sec == '0 && res_nsec == '0)
    `TSAU_ASSERT_NXT(a_hold_on_stall, clk, rst_n, !adv, $stable(u_valid_reg) && $stable(p_valid_reg))
    `TSAU_ASSERT_NXT(a_u_to_out, clk, rst_n, adv && u_valid_reg, out_valid)
endmodule
`default_nettype wire

>>> bench/testbench.sv
// Self-checking testbench for the timestamp arithmetic unit.
`timescale 1ns / 1ps
`default_nettype none
module testbench;
    import tsau_pkg::*;

    typedef struct packed {
        cmd_t               op;
        logic signed [63:0] a_s;
        logic [29:0]        a_n;
        logic signed [63:0] b_s;
        logic [29:0]        b_n;
        logic signed [31:0] fac;
    } stamp_op_t;

    typedef struct packed {
        logic signed [63:0] sec;
        logic signed [30:0] nsec;
        status_t            st;
    } stamp_res_t;

    typedef struct packed {
        stamp_op_t  op;
        logic       known;
        stamp_res_t res;
    } stim_row_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_ready;
    logic [1:0] cmd = '0;
    logic signed [63:0] a_sec = '0;
    logic [29:0] a_nsec = '0;
    logic signed [63:0] b_sec = '0;
    logic [29:0] b_nsec = '0;
    logic signed [31:0] factor = '0;
    logic out_valid;
    logic out_ready = 1'b0;
    logic signed [63:0] res_sec;
    logic signed [30:0] res_nsec;
    logic [1:0] status;

    stamp_res_t pending_results[$];
    int errors = 0;
    bit calm = 1'b0;

    timespec_arithmetic_unit u_dut (
        .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
        .cmd(cmd), .a_sec(a_sec), .a_nsec(a_nsec), .b_sec(b_sec),
        .b_nsec(b_nsec), .factor(factor), .out_valid(out_valid),
        .out_ready(out_ready), .res_sec(res_sec), .res_nsec(res_nsec),
        .status(status)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // Seconds are worked out exactly in 128 bits, then wrapped.
    function automatic stamp_res_t timespec_result(stamp_op_t w);
        logic signed [127:0] s, am, fm, q, r;
        logic signed [63:0] ns, an, bn, f64, t;
        stamp_res_t res;
        am  = w.a_s;
        fm  = w.fac;
        an  = {34'd0, w.a_n};
        bn  = {34'd0, w.b_n};
        f64 = w.fac;
        s   = '0;
        ns  = '0;
        case (w.op)
            CMD_DIFF:
            begin
                s  = am - 128'(signed'(w.b_s));
                ns = an - bn;
                repeat (2)
                    if (ns < 0)
                    begin
                        ns = ns + 64'sd1000000000;
                        s  = s - 128'sd1;
                    end
            end
            CMD_SUM:
            begin
                s  = am + 128'(signed'(w.b_s));
                ns = an + bn;
                repeat (2)
                    if (ns >= 64'sd1000000000)
                    begin
                        ns = ns - 64'sd1000000000;
                        s  = s + 128'sd1;
                    end
            end
            CMD_MUL:
            begin
                t  = f64 * an;
                s  = am * fm + 128'(t / 64'sd1000000000);
                ns = t % 64'sd1000000000;
            end
            default:
            begin
                if (w.fac == 0)
                begin
                    res.sec  = '0;
                    res.nsec = '0;
                    res.st   = ST_DIV_ZERO;
                    return res;
                end
                q  = am / fm;
                r  = am % fm;
                t  = (64'(r) * 64'sd1000000000 + an) / f64;
                s  = q + 128'(t / 64'sd1000000000);
                ns = t % 64'sd1000000000;
            end
        endcase
        res.sec  = s[63:0];
        res.nsec = ns[30:0];
        res.st   = (s[127:63] == '0 || s[127:63] == '1) ? ST_OK : ST_OVERFLOW;
        return res;
    endfunction

    function automatic logic [63:0] pick_sec();
        case ($urandom_range(0, 5))
            0: return 64'h8000000000000000;
            1: return 64'h7fffffffffffffff;
            2: return 64'(signed'($urandom_range(0, 2000)) - 1000);
            default: return {$urandom, $urandom};
        endcase
    endfunction

    function automatic logic [29:0] pick_nsec();
        case ($urandom_range(0, 9))
            0: return 30'($urandom_range(0, 30'h3fffffff));
            1: return 30'd999999999;
            2: return 30'd0;
            default: return 30'($urandom_range(0, 999999999));
        endcase
    endfunction

    function automatic logic [31:0] pick_factor();
        case ($urandom_range(0, 7))
            0: return 32'h80000000;
            1: return 32'h7fffffff;
            2: return $urandom_range(0, 1) ? 32'd1 : 32'hffffffff;
            3: return 32'd0;
            4: return 32'(signed'($urandom_range(0, 200)) - 100);
            default: return $urandom;
        endcase
    endfunction

    // Hold the word until accepted, then queue its expected result.
    task automatic send_word(stamp_op_t w, logic known, stamp_res_t want);
        while (!calm && $urandom_range(0, 99) < 27)
        begin
            in_valid = 1'b0;
            @(negedge clk);
        end
        cmd    = w.op;
        a_sec  = w.a_s;
        a_nsec = w.a_n;
        b_sec  = w.b_s;
        b_nsec = w.b_n;
        factor = w.fac;
        in_valid = 1'b1;
        do
            @(posedge clk);
        while (!in_ready);
        pending_results.push_back(known ? want : timespec_result(w));
        @(negedge clk);
    endtask

    always @(negedge clk)
        out_ready <= calm || ($urandom_range(0, 99) >= 27);

    always @(posedge clk)
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_results.size() == 0)
            begin
                $display("%t: unexpected result sec=%0d nsec=%0d status=%0d",
                         $realtime, res_sec, res_nsec, status);
                errors++;
            end
            else
            begin
                stamp_res_t e;
                e = pending_results.pop_front();
                if (res_sec !== e.sec)
                begin
                    $display("%t: res_sec expected %0d actual %0d", $realtime, e.sec, res_sec);
                    errors++;
                end
                if (res_nsec !== e.nsec)
                begin
                    $display("%t: res_nsec expected %0d actual %0d",
                             $realtime, e.nsec, res_nsec);
                    errors++;
                end
                if (status !== e.st)
                begin
                    $display("%t: status expected %0d actual %0d", $realtime, e.st, status);
                    errors++;
                end
            end
        end

    initial
    begin
        #2000000;
        $display("[timespec_arithmetic_unit] ERROR");
        $finish;
    end

    localparam logic [63:0] SMIN = 64'h8000000000000000;
    localparam logic [63:0] SMAX = 64'h7fffffffffffffff;
    localparam logic [29:0] NMAX = 30'd999999999;
    localparam logic [29:0] NTOP = 30'h3fffffff;

    stim_row_t directed[] = '{
        '{'{CMD_DIFF, 64'd0, 30'd0, 64'd0, 30'd0, 32'd0}, 1'b1, '{64'd0, 31'd0, ST_OK}},
        '{'{CMD_DIV, 64'd5, 30'd7, 64'd0, 30'd0, 32'd0}, 1'b1, '{64'd0, 31'd0, ST_DIV_ZERO}},
        '{'{CMD_DIV, SMIN, 30'd0, 64'd0, 30'd0, 32'hffffffff}, 1'b1,
          '{SMIN, 31'd0, ST_OVERFLOW}},
        '{'{CMD_SUM, 64'd1, 30'd500000000, 64'd2, 30'd500000000, 32'd0}, 1'b1,
          '{64'd4, 31'd0, ST_OK}},
        '{'{CMD_DIFF, 64'd3, 30'd0, 64'd1, 30'd1, 32'd9}, 1'b1,
          '{64'd1, 31'd999999999, ST_OK}},
        '{'{CMD_DIFF, SMIN, 30'd0, SMAX, NMAX, 32'd0}, 1'b0, '0},
        '{'{CMD_DIFF, SMAX, 30'd0, 64'd0, NTOP, 32'd0}, 1'b0, '0},
        '{'{CMD_SUM, SMAX, NMAX, SMAX, NMAX, 32'd0}, 1'b0, '0},
        '{'{CMD_SUM, SMIN, NTOP, SMIN, NTOP, 32'd0}, 1'b0, '0},
        '{'{CMD_SUM, -64'sd1, 30'd0, 64'd0, 30'd0, 32'd0}, 1'b0, '0},
        '{'{CMD_MUL, SMAX, NMAX, 64'd5, 30'd5, 32'h7fffffff}, 1'b0, '0},
        '{'{CMD_MUL, SMIN, NTOP, 64'd0, 30'd0, 32'h80000000}, 1'b0, '0},
        '{'{CMD_MUL, 64'd7, 30'd300000000, 64'd0, 30'd0, 32'hfffffffd}, 1'b0, '0},
        '{'{CMD_MUL, SMIN, 30'd0, 64'd0, 30'd0, 32'hffffffff}, 1'b0, '0},
        '{'{CMD_MUL, 64'd9, 30'd9, 64'd0, 30'd0, 32'd0}, 1'b0, '0},
        '{'{CMD_DIV, SMAX, NMAX, 64'd0, 30'd0, 32'd1}, 1'b0, '0},
        '{'{CMD_DIV, SMIN, NTOP, 64'd0, 30'd0, 32'h7fffffff}, 1'b0, '0},
        '{'{CMD_DIV, -64'sd7, 30'd1, 64'd0, 30'd0, 32'd2}, 1'b0, '0},
        '{'{CMD_DIV, 64'd7, NMAX, 64'd0, 30'd0, 32'h80000000}, 1'b0, '0},
        '{'{CMD_DIV, 64'd7, NTOP, 64'd0, 30'd0, 32'hfffffffd}, 1'b0, '0}
    };

    initial
    begin
        stamp_op_t w;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        foreach (directed[i])
            send_word(directed[i].op, directed[i].known, directed[i].res);
        for (int n = 0; n < 700; n++)
        begin
            calm = (n >= 300 && n < 400);
            if (n == 150)
            begin
                in_valid = 1'b0;
                wait (pending_results.size() == 0);
                @(negedge clk);
            end
            w.op  = cmd_t'($urandom_range(0, 3));
            w.a_s = pick_sec();
            w.a_n = pick_nsec();
            w.b_s = pick_sec();
            w.b_n = pick_nsec();
            w.fac = pick_factor();
            send_word(w, 1'b0, '0);
        end
        in_valid = 1'b0;
        calm = 1'b0;
        wait (pending_results.size() == 0);
        repeat (200) @(posedge clk);
        if (errors == 0)
            $display("[timespec_arithmetic_unit] OK");
        else
            $display("[timespec_arithmetic_unit] ERROR");
        $finish;
    end
endmodule
`default_nettype wire

>>> files.f
+incdir+design
design/tsau_pkg.sv
design/tsau_div_cell.sv
design/tsau_div_chain.sv
design/timespec_arithmetic_unit.sv
bench/testbench.sv
